>>> src/cwvd_pkg.sv
// ----------------------------------------------------------------------------
// cwvd_pkg
// Shared widths and constants of the weighted volume dissimilarity block.
// ----------------------------------------------------------------------------
`default_nettype none
package cwvd_pkg;
    localparam int SAMPLE_W        = 24;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 56;
    localparam int ZETA_W          = 40;
    localparam int CORT_W          = 16;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SUM_W           = 64;
    localparam int VOL_W           = 37;
    localparam int MUL_W           = 32;
    localparam int PROD_W          = 64;
    localparam int ROOT_W          = 31;
    localparam int SHIFT_W         = 5;
    localparam int EXTRA_W         = 7;
    localparam int QUOT_W          = 32;
    localparam int DIV_CNT_W       = 8;
    localparam int PHI_W           = 18;
    localparam int TERM_CNT_W      = 4;
    localparam int TERMS           = 12;
    localparam int SQUARINGS       = 3;
    localparam int CORT_FRAC_SHIFT = 16;
    localparam logic [QUOT_W-1:0] QUOT_LIMIT = QUOT_W'(1 << 20);
    localparam logic [63:0] NORM_FLOOR = 64'd1 << 60;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF   = 64'd1 << 29;
endpackage
`default_nettype wire

>>> src/cwvd_mul.sv
// ----------------------------------------------------------------------------
// cwvd_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module cwvd_mul (
    input  wire logic                       i_clk,
    input  wire logic [cwvd_pkg::MUL_W-1:0] i_a,
    input  wire logic [cwvd_pkg::MUL_W-1:0] i_b,
    output logic [cwvd_pkg::PROD_W-1:0]     o_prod
);
    import cwvd_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

>>> src/cwvd_sqrt.sv
// ----------------------------------------------------------------------------
// cwvd_sqrt
// Normalizes a nonzero value by even shifts until it is at least 2^60, then takes
// its floor square root one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cwvd_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [cwvd_pkg::SUM_W-1:0]   i_value,
    output logic                              o_done,
    output logic [cwvd_pkg::ROOT_W-1:0]       o_root,
    output logic [cwvd_pkg::SHIFT_W-1:0]      o_shift
);
    import cwvd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_NORM = 3'b010,
        S_ROOT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_v, n_v;
    logic [SUM_W-1:0]   r_res, n_res;
    logic [SUM_W-1:0]   r_bit, n_bit;
    logic [SHIFT_W-1:0] r_k, n_k;
    logic               r_done, n_done;
    logic [SUM_W-1:0]   trial;

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_res   = r_res;
        n_bit   = r_bit;
        n_k     = r_k;
        n_done  = 1'b0;
        trial   = r_res + r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_v     = i_value;
                    n_k     = '0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_v < NORM_FLOOR) begin
                    n_v = {r_v[SUM_W-3:0], 2'b00};
                    n_k = r_k + SHIFT_W'(1);
                end else begin
                    n_res   = '0;
                    n_bit   = NORM_FLOOR;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_v >= trial) begin
                    n_v   = r_v - trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == SUM_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_k   <= n_k;
    end

    assign o_done  = r_done;
    assign o_root  = r_res[ROOT_W-1:0];
    assign o_shift = r_k;
endmodule
`default_nettype wire

>>> src/cwvd_div.sv
// ----------------------------------------------------------------------------
// cwvd_div
// Restoring divider, one quotient bit per cycle, over the 64 dividend bits
// and a number of extra zero bits; optional saturation of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module cwvd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_sat,
    input  wire logic [cwvd_pkg::SUM_W-1:0]    i_num,
    input  wire logic [cwvd_pkg::SUM_W-1:0]    i_den,
    input  wire logic [cwvd_pkg::EXTRA_W-1:0]  i_extra,
    output logic                               o_done,
    output logic [cwvd_pkg::QUOT_W-1:0]        o_quot
);
    import cwvd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_sat;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_num;
    logic [SUM_W-1:0]     r_den;
    logic [SUM_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_quot;
    logic [SUM_W-1:0]     rem_sh;
    logic                 ge;
    logic [QUOT_W:0]      q_wide;
    logic [QUOT_W-1:0]    q_next;

    always_comb begin
        rem_sh = {r_rem[SUM_W-2:0], r_num[SUM_W-1]};
        ge     = (rem_sh >= r_den);
        q_wide = {r_quot, ge};
        if (r_sat && (q_wide > (QUOT_W+1)'(QUOT_LIMIT))) begin
            q_next = QUOT_LIMIT;
        end else begin
            q_next = q_wide[QUOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DIV_CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_sat  <= i_sat;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= DIV_CNT_W'(SUM_W) + DIV_CNT_W'(i_extra);
        end else if (r_busy) begin
            r_num  <= {r_num[SUM_W-2:0], 1'b0};
            r_rem  <= ge ? (rem_sh - r_den) : rem_sh;
            r_quot <= q_next;
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> src/cort_weighted_volume_dissimilarity.sv
// ----------------------------------------------------------------------------
// cort_weighted_volume_dissimilarity
// Accumulates difference sums and volumes of two series, and on the last pair
// emits CORT, the PHI-weighted volume difference and a degenerate flag.
// Input is accepted only in the idle state: a plain pair holds it off while its three
// products go through the shared multiplier; a first pair returns to idle directly.
// A last pair then runs two normalized roots, an 80+kx+ky step division, 12 series
// terms, 3 squarings and a 64-step division; a degenerate series skips these steps.
// Reset (synchronous, active low) clears all sums and the control state.
// ----------------------------------------------------------------------------
`default_nettype none
module cort_weighted_volume_dissimilarity #(
    parameter int MAX_SAMPLES = cwvd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = cwvd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [cwvd_pkg::IN_DATA_W-1:0]  i_s_tdata,   // x_sample, y_sample
    input  wire logic                            i_s_tuser,   // first_pair
    input  wire logic                            i_s_tlast,   // last_pair
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [cwvd_pkg::OUT_DATA_W-1:0]      o_m_tdata,   // zeta, cort
    output logic                                 o_m_tuser    // degenerate
);
    import cwvd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int DIFF_W = SAMPLE_BITS + 1;

    typedef enum logic [20:0] {
        S_IDLE = 21'h000001,
        S_MXY  = 21'h000002,
        S_MXX  = 21'h000004,
        S_MYY  = 21'h000008,
        S_MADD = 21'h000010,
        S_CHK  = 21'h000020,
        S_WSQX = 21'h000040,
        S_WSQY = 21'h000080,
        S_MD   = 21'h000100,
        S_MDW  = 21'h000200,
        S_WDIV = 21'h000400,
        S_TMUL = 21'h000800,
        S_TMW  = 21'h001000,
        S_TDIV = 21'h002000,
        S_SQ   = 21'h004000,
        S_SQW  = 21'h008000,
        S_PW   = 21'h010000,
        S_ZH   = 21'h020000,
        S_ZL   = 21'h040000,
        S_ZC   = 21'h080000,
        S_FIN  = 21'h100000
    } t_state;

    t_state                  r_state;
    logic [SAMPLE_BITS-1:0]  r_prev_x, r_prev_y;
    logic [SUM_W-1:0]        r_cross, r_sxx, r_syy;
    logic [VOL_W-1:0]        r_volx, r_voly;
    logic [CNT_W-1:0]        r_count;
    logic [SAMPLE_BITS-1:0]  r_dxm, r_dym;
    logic                    r_dsign;
    logic                    r_last;
    logic [ROOT_W-1:0]       r_rx, r_ry;
    logic [SHIFT_W-1:0]      r_kx, r_ky;
    logic [CORT_W-1:0]       r_cort;
    logic                    r_pneg;
    logic [MUL_W-1:0]        r_h;
    logic [MUL_W-1:0]        r_term;
    logic [MUL_W-1:0]        r_sum;
    logic [TERM_CNT_W-1:0]   r_n;
    logic [1:0]              r_sqc;
    logic [PHI_W-1:0]        r_phi;
    logic [VOL_W-1:0]        r_dm;
    logic                    r_dneg;
    logic [PROD_W-1:0]       r_zhi;
    logic [ZETA_W-1:0]       r_zeta;
    logic                    r_degen;
    logic                    r_ovalid;
    logic [OUT_DATA_W-1:0]   r_odata;
    logic                    r_ouser;

    logic                    accept;
    logic [SAMPLE_BITS-1:0]  x_in, y_in;
    logic [DIFF_W-1:0]       dx, dy;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       prod;
    logic                    sq_start, sq_done;
    logic [SUM_W-1:0]        sq_value;
    logic [ROOT_W-1:0]       sq_root;
    logic [SHIFT_W-1:0]      sq_shift;
    logic                    dv_start, dv_sat, dv_done;
    logic [SUM_W-1:0]        dv_num, dv_den;
    logic [EXTRA_W-1:0]      dv_extra;
    logic [QUOT_W-1:0]       dv_quot;
    logic [PROD_W-1:0]       rnd;
    logic [MUL_W-1:0]        rnd_q30;
    logic [MUL_W-1:0]        den_p;
    logic [SUM_W-1:0]        cross_abs;
    logic [16:0]             qc, qh;
    logic [CORT_W-1:0]       cort_pos;
    logic [PROD_W-1:0]       ztot;
    logic [47:0]             zm;
    logic [VOL_W:0]          vdiff;
    logic                    nondegen;

    assign accept   = i_s_tvalid && o_s_tready;
    assign x_in     = i_s_tdata[SAMPLE_BITS-1:0];
    assign y_in     = i_s_tdata[SAMPLE_W+SAMPLE_BITS-1:SAMPLE_W];
    assign dx       = {1'b0, x_in} - {1'b0, r_prev_x};
    assign dy       = {1'b0, y_in} - {1'b0, r_prev_y};
    assign rnd      = prod + Q30_HALF;
    assign rnd_q30  = rnd[30+MUL_W-1:30];
    assign den_p    = rnd_q30 + Q30_ONE[MUL_W-1:0];
    assign cross_abs = r_cross[SUM_W-1] ? (SUM_W'(0) - r_cross) : r_cross;
    assign nondegen = (r_sxx != '0) && (r_syy != '0);
    assign vdiff    = {1'b0, r_volx} - {1'b0, r_voly};

    always_comb begin
        qc       = (dv_quot > QUOT_W'(65536)) ? 17'd65536 : dv_quot[16:0];
        qh       = (qc + 17'd1) >> 1;
        cort_pos = (qh > 17'd32767) ? CORT_W'(32767) : qh[CORT_W-1:0];
        ztot     = {r_zhi[PROD_W-CORT_FRAC_SHIFT-1:0], CORT_FRAC_SHIFT'(0)} + prod
                 + PROD_W'(1 << 15);
        zm       = ztot[63:16];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MXY:  begin mul_a = MUL_W'(r_dxm); mul_b = MUL_W'(r_dym); end
            S_MXX:  begin mul_a = MUL_W'(r_dxm); mul_b = MUL_W'(r_dxm); end
            S_MYY:  begin mul_a = MUL_W'(r_dym); mul_b = MUL_W'(r_dym); end
            S_MD:   begin mul_a = MUL_W'(r_rx);  mul_b = MUL_W'(r_ry);  end
            S_TMUL: begin mul_a = r_term;        mul_b = r_h;           end
            S_SQ:   begin mul_a = r_sum;         mul_b = r_sum;         end
            S_ZH:   begin mul_a = MUL_W'(r_dm[VOL_W-1:16]); mul_b = MUL_W'(r_phi); end
            S_ZL:   begin mul_a = MUL_W'(r_dm[15:0]);       mul_b = MUL_W'(r_phi); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        sq_start = ((r_state == S_CHK) && nondegen) || ((r_state == S_WSQX) && sq_done);
        sq_value = (r_state == S_CHK) ? r_sxx : r_syy;
        dv_start = 1'b0;
        dv_sat   = 1'b1;
        dv_num   = '0;
        dv_den   = '0;
        dv_extra = '0;
        if (r_state == S_MDW) begin
            dv_start = 1'b1;
            dv_num   = cross_abs;
            dv_den   = prod;
            dv_extra = EXTRA_W'(r_kx) + EXTRA_W'(r_ky) + EXTRA_W'(CORT_FRAC_SHIFT);
        end else if (r_state == S_TMW) begin
            dv_start = 1'b1;
            dv_sat   = 1'b0;
            dv_num   = SUM_W'(rnd_q30);
            dv_den   = SUM_W'(r_n);
        end else if ((r_state == S_SQW) && (r_sqc == 2'(SQUARINGS - 1))) begin
            dv_start = 1'b1;
            dv_num   = (SUM_W'(rnd_q30) << 17) + (SUM_W'(den_p) >> 1);
            dv_den   = SUM_W'(den_p);
        end
    end

    cwvd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    cwvd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root),
        .o_shift (sq_shift)
    );

    cwvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_sat   (dv_sat),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_extra (dv_extra),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_cross  <= '0;
            r_sxx    <= '0;
            r_syy    <= '0;
            r_volx   <= '0;
            r_voly   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_s_tlast;
                        if (i_s_tuser) begin
                            r_cross  <= '0;
                            r_sxx    <= '0;
                            r_syy    <= '0;
                            r_volx   <= VOL_W'(x_in);
                            r_voly   <= VOL_W'(y_in);
                            r_prev_x <= x_in;
                            r_prev_y <= y_in;
                            r_count  <= CNT_W'(1);
                            r_state  <= i_s_tlast ? S_CHK : S_IDLE;
                        end else if (r_count < CNT_W'(MAX_SAMPLES)) begin
                            r_dxm    <= dx[DIFF_W-1] ? SAMPLE_BITS'(-dx)
                                                     : dx[SAMPLE_BITS-1:0];
                            r_dym    <= dy[DIFF_W-1] ? SAMPLE_BITS'(-dy)
                                                     : dy[SAMPLE_BITS-1:0];
                            r_dsign  <= dx[DIFF_W-1] ^ dy[DIFF_W-1];
                            r_volx   <= r_volx + VOL_W'(x_in);
                            r_voly   <= r_voly + VOL_W'(y_in);
                            r_prev_x <= x_in;
                            r_prev_y <= y_in;
                            r_count  <= r_count + CNT_W'(1);
                            r_state  <= S_MXY;
                        end else begin
                            r_state  <= i_s_tlast ? S_CHK : S_IDLE;
                        end
                    end
                end
                S_MXY: r_state <= S_MXX;
                S_MXX: begin
                    r_cross <= r_dsign ? (r_cross - prod) : (r_cross + prod);
                    r_state <= S_MYY;
                end
                S_MYY: begin
                    r_sxx   <= r_sxx + prod;
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    r_syy   <= r_syy + prod;
                    r_state <= r_last ? S_CHK : S_IDLE;
                end
                S_CHK: begin
                    r_dm    <= vdiff[VOL_W] ? VOL_W'(-vdiff) : vdiff[VOL_W-1:0];
                    r_dneg  <= vdiff[VOL_W];
                    if (nondegen) begin
                        r_degen <= 1'b0;
                        r_state <= S_WSQX;
                    end else begin
                        r_degen <= 1'b1;
                        r_zeta  <= '0;
                        r_cort  <= '0;
                        r_state <= S_FIN;
                    end
                end
                S_WSQX: begin
                    if (sq_done) begin
                        r_rx    <= sq_root;
                        r_kx    <= sq_shift;
                        r_state <= S_WSQY;
                    end
                end
                S_WSQY: begin
                    if (sq_done) begin
                        r_ry    <= sq_root;
                        r_ky    <= sq_shift;
                        r_state <= S_MD;
                    end
                end
                S_MD:  r_state <= S_MDW;
                S_MDW: r_state <= S_WDIV;
                S_WDIV: begin
                    if (dv_done) begin
                        if (r_cross[SUM_W-1]) begin
                            r_cort <= CORT_W'(-qh);
                            r_h    <= MUL_W'(qh) << 13;
                            r_pneg <= (qh != '0);
                        end else begin
                            r_cort <= cort_pos;
                            r_h    <= MUL_W'(cort_pos) << 13;
                            r_pneg <= 1'b0;
                        end
                        r_sum   <= Q30_ONE[MUL_W-1:0];
                        r_term  <= Q30_ONE[MUL_W-1:0];
                        r_n     <= TERM_CNT_W'(1);
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: r_state <= S_TMW;
                S_TMW:  r_state <= S_TDIV;
                S_TDIV: begin
                    if (dv_done) begin
                        r_term <= dv_quot;
                        r_sum  <= r_n[0] ? (r_sum - dv_quot) : (r_sum + dv_quot);
                        if (r_n == TERM_CNT_W'(TERMS)) begin
                            r_sqc   <= '0;
                            r_state <= S_SQ;
                        end else begin
                            r_n     <= r_n + TERM_CNT_W'(1);
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: begin
                    r_sum <= rnd_q30;
                    r_sqc <= r_sqc + 2'd1;
                    r_state <= (r_sqc == 2'(SQUARINGS - 1)) ? S_PW : S_SQ;
                end
                S_PW: begin
                    if (dv_done) begin
                        r_phi   <= r_pneg ? (PHI_W'(1 << 17) - dv_quot[PHI_W-1:0])
                                          : dv_quot[PHI_W-1:0];
                        r_state <= S_ZH;
                    end
                end
                S_ZH: r_state <= S_ZL;
                S_ZL: begin
                    r_zhi   <= prod;
                    r_state <= S_ZC;
                end
                S_ZC: begin
                    if (r_dneg) begin
                        r_zeta <= (zm > 48'(64'd1 << 39)) ? ZETA_W'(64'd1 << 39)
                                                          : ZETA_W'(-zm);
                    end else begin
                        r_zeta <= (zm > 48'((64'd1 << 39) - 1))
                                ? ZETA_W'((64'd1 << 39) - 1) : zm[ZETA_W-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if ((r_state == S_FIN) && (!r_ovalid || i_m_tready)) begin
            r_odata <= {r_cort, r_zeta};
            r_ouser <= r_degen;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
endmodule
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pairs of x/y samples with first and last marks into the weighted
// volume dissimilarity block. Holds its own fixed-point predictor of the
// sums, CORT, PHI and zeta. Checks every result in order through a small
// scoreboard, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
class cwvd_scoreboard;
    typedef struct {
        logic [39:0] zeta;
        logic [15:0] cort;
        logic        degenerate;
    } result_t;

    result_t         pending[$];
    int              errors;
    logic [63:0]     prev_x, prev_y;
    longint          cross_acc;
    logic [63:0]     sqx_acc, sqy_acc, volx_acc, voly_acc;
    int unsigned     pair_count;

    function new();
        errors     = 0;
        prev_x     = 0;
        prev_y     = 0;
        cross_acc  = 0;
        sqx_acc    = 0;
        sqy_acc    = 0;
        volx_acc   = 0;
        voly_acc   = 0;
        pair_count = 0;
    endfunction

    function logic [63:0] rmul(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function logic [63:0] scaled_root(logic [63:0] v, output int k);
        k = 0;
        while (v < (64'd1 << 60)) begin
            v = v << 2;
            k++;
        end
        return isqrt(v);
    endfunction

    function logic [63:0] ratio(logic [63:0] c, int s, logic [63:0] d);
        logic [63:0] r, q, b;
        r = 0;
        q = 0;
        for (int i = 63 + s; i >= 0; i--) begin
            b = (i >= s) ? ((c >> (i - s)) & 64'd1) : 64'd0;
            r = (r << 1) | b;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
            if (q > (64'd1 << 20)) q = 64'd1 << 20;
        end
        return q;
    endfunction

    function logic [63:0] phi_weight(int cort);
        logic [63:0] m, h, acc, term, den, pos;
        m    = (cort < 0) ? 64'(-cort) : 64'(cort);
        h    = m << 13;
        acc  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            term = rmul(term, h) / n;
            if (n % 2) acc = acc - term;
            else       acc = acc + term;
        end
        for (int n = 0; n < 3; n++) acc = rmul(acc, acc);
        den = acc + (64'd1 << 30);
        pos = ((acc << 17) + (den >> 1)) / den;
        return (cort < 0) ? (64'd1 << 17) - pos : pos;
    endfunction

    function void note_pair(logic [23:0] x, logic [23:0] y, logic first, logic last);
        result_t     res;
        longint      dx, dy, diff;
        int          kx, ky, cort;
        logic [63:0] rx, ry, mag, q, phi, dm, zm;
        if (first) begin
            cross_acc  = 0;
            sqx_acc    = 0;
            sqy_acc    = 0;
            volx_acc   = 64'(x);
            voly_acc   = 64'(y);
            prev_x     = 64'(x);
            prev_y     = 64'(y);
            pair_count = 1;
        end else if (pair_count < 4096) begin
            dx         = longint'(x) - longint'(prev_x);
            dy         = longint'(y) - longint'(prev_y);
            cross_acc  = cross_acc + dx * dy;
            sqx_acc    = sqx_acc + 64'(dx * dx);
            sqy_acc    = sqy_acc + 64'(dy * dy);
            volx_acc   = volx_acc + 64'(x);
            voly_acc   = voly_acc + 64'(y);
            prev_x     = 64'(x);
            prev_y     = 64'(y);
            pair_count++;
        end
        if (!last) return;
        res.zeta       = 0;
        res.cort       = 0;
        res.degenerate = 0;
        if (sqx_acc == 0 || sqy_acc == 0) begin
            res.degenerate = 1;
        end else begin
            rx  = scaled_root(sqx_acc, kx);
            ry  = scaled_root(sqy_acc, ky);
            mag = (cross_acc < 0) ? 64'(-cross_acc) : 64'(cross_acc);
            q   = ratio(mag, kx + ky + 16, rx * ry);
            if (q > 65536) q = 65536;
            q = (q + 1) >> 1;
            if (cross_acc < 0) cort = -int'(q);
            else               cort = (q > 32767) ? 32767 : int'(q);
            phi  = phi_weight(cort);
            diff = longint'(volx_acc) - longint'(voly_acc);
            dm   = (diff < 0) ? 64'(-diff) : 64'(diff);
            zm   = (dm * phi + (64'd1 << 15)) >> 16;
            if (diff < 0) begin
                if (zm > (64'd1 << 39)) zm = 64'd1 << 39;
                res.zeta = 40'(-longint'(zm));
            end else begin
                if (zm > (64'd1 << 39) - 1) zm = (64'd1 << 39) - 1;
                res.zeta = 40'(zm);
            end
            res.cort = 16'(cort);
        end
        pending.push_back(res);
    endfunction

    function void check_result(logic [55:0] data, logic user);
        result_t exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result zeta=%h cort=%h degenerate=%b",
                     $time, data[39:0], data[55:40], user);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (data[39:0] !== exp_r.zeta) begin
            $display("%0t: zeta expected %h actual %h", $time, exp_r.zeta, data[39:0]);
            errors++;
        end
        if (data[55:40] !== exp_r.cort) begin
            $display("%0t: cort expected %h actual %h", $time, exp_r.cort, data[55:40]);
            errors++;
        end
        if (user !== exp_r.degenerate) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_r.degenerate, user);
            errors++;
        end
    endfunction
endclass

module testbench;
    import cwvd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // x_sample, y_sample
    logic                  i_s_tuser;   // first_pair
    logic                  i_s_tlast;   // last_pair
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // zeta, cort
    logic                  o_m_tuser;   // degenerate

    cwvd_scoreboard board = new();
    bit             quiet_gaps;
    bit             long_stall_done;
    int             stall_cycles;
    int             sent;

    cort_weighted_volume_dissimilarity DUT (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pair(logic [23:0] x, logic [23:0] y, logic first, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tuser  <= first;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pair(x, y, first, last);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_series(int len, int mode);
        logic [23:0] x, y, bx, by;
        int          step;
        bx = 24'($urandom());
        by = 24'($urandom());
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: begin
                    x = 24'($urandom());
                    y = 24'($urandom());
                end
                1: begin
                    x = bx + 24'($urandom_range(0, 4095));
                    y = x + 24'($urandom_range(0, 255));
                end
                2: begin
                    step = $urandom_range(0, 9999);
                    x = bx + 24'(i * step);
                    y = by - 24'(i * step) + 24'($urandom_range(0, 300));
                end
                default: begin
                    x = 24'($urandom_range(0, 255));
                    y = 24'($urandom_range(0, 255));
                end
            endcase
            send_pair(x, y, i == 0, i == len - 1);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_s_tlast  = 1'b0;
        quiet_gaps = 1'b0;
        sent       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pairs before any first mark
        send_pair(24'h000100, 24'h000300, 1'b0, 1'b0);
        send_pair(24'h000500, 24'h000200, 1'b0, 1'b0);
        send_pair(24'h000900, 24'h000800, 1'b0, 1'b1);
        // single-pair series
        send_pair(24'hFFFFFF, 24'h000000, 1'b1, 1'b1);
        // flat series
        for (int i = 0; i < 4; i++) send_pair(24'h123456, 24'hABCDEF, i == 0, i == 3);
        // identical ramps, then opposite ramps
        for (int i = 0; i < 4; i++)
            send_pair(24'(i * 24'h100000), 24'(i * 24'h100000), i == 0, i == 3);
        for (int i = 0; i < 4; i++)
            send_pair(24'(i * 24'h300000), 24'hFFFFFF - 24'(i * 24'h300000), i == 0, i == 3);
        // full-scale alternation
        for (int i = 0; i < 4; i++)
            send_pair((i % 2) ? 24'hFFFFFF : 24'h0, (i % 2) ? 24'h0 : 24'hFFFFFF, i == 0, i == 3);
        // continue past a result
        send_pair(24'h00FF00, 24'h00AA00, 1'b0, 1'b0);
        send_pair(24'h0000FF, 24'hFF0000, 1'b0, 1'b1);

        while (sent < 950) begin
            quiet_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send_pair(24'($urandom()), 24'($urandom()), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0);
            end else begin
                send_series($urandom_range(2, 30), $urandom_range(0, 3));
            end
        end
        i_s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        i_m_tready      = 1'b0;
        stall_cycles    = 0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_cycles > 0) begin
                stall_cycles--;
                i_m_tready <= 1'b0;
            end else if (sent == 40 && i_s_tvalid && !long_stall_done) begin
                stall_cycles    = 6000;
                long_stall_done = 1'b1;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 8) begin
                stall_cycles = $urandom_range(1, 200);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
    end

    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
